// ----- rtl/core/spq_pkg.sv -----
// Shared constants and word types for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [ELEM_WIDTH-1:0] elem;
        logic [PRIO_WIDTH-1:0] priority_req;
    } t_in_word;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0] front_elem;
        logic [PRIO_WIDTH-1:0] front_priority;
        logic [COUNT_W-1:0]    item_count;
        logic                  is_empty;
        logic                  is_full;
        logic                  error;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- rtl/core/spq_ctrl.sv -----
// Controller: sequences accept and execute, and marks the result word.
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_valid,
    output spq_pkg::t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_valid;

    assign busy       = (r_state == ST_EXEC);
    assign o_cmd.load = start && !busy;
    assign o_cmd.exec = (r_state == ST_EXEC);
    assign o_valid    = r_valid;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = o_cmd.load ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_EXEC);
        end
    end

endmodule

// ----- rtl/core/spq_datapath.sv -----
// Datapath: row of sorted cells with parallel compare-and-shift, count and result word.
`timescale 1ns / 1ps

module spq_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_dp_cmd    i_cmd,
    input  spq_pkg::t_in_word   i_word,
    output spq_pkg::t_out_word  o_word
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int CW  = spq_pkg::COUNT_W;

    logic [spq_pkg::ELEM_WIDTH-1:0] r_elem [CAP];
    logic [spq_pkg::PRIO_WIDTH-1:0] r_prio [CAP];
    logic [spq_pkg::ELEM_WIDTH-1:0] n_elem [CAP];
    logic [spq_pkg::PRIO_WIDTH-1:0] n_prio [CAP];
    logic [CW-1:0]                  r_count, n_count;
    spq_pkg::t_in_word              r_in;
    spq_pkg::t_out_word             r_out, n_out;
    logic [CAP-1:0]                 le;
    logic                           full, empty, fault;

    assign full  = (r_count == CW'(CAP));
    assign empty = (r_count == '0);
    assign fault = (r_in.mode == spq_pkg::MODE_ENQ) ? full : empty;

    // Cells that stay ahead of the new entry: valid and priority not above it.
    always_comb begin
        for (int k = 0; k < CAP; k++) begin
            le[k] = (CW'(k) < r_count) && (r_prio[k] <= r_in.priority_req);
        end
    end

    always_comb begin
        for (int k = 0; k < CAP; k++) begin
            n_elem[k] = r_elem[k];
            n_prio[k] = r_prio[k];
        end
        n_count = r_count;
        if (!fault) begin
            if (r_in.mode == spq_pkg::MODE_ENQ) begin
                n_count = r_count + CW'(1);
                for (int k = 0; k < CAP; k++) begin
                    if (!le[k]) begin
                        if (k == 0) begin
                            n_elem[k] = r_in.elem;
                            n_prio[k] = r_in.priority_req;
                        end else if (le[k-1]) begin
                            n_elem[k] = r_in.elem;
                            n_prio[k] = r_in.priority_req;
                        end else begin
                            n_elem[k] = r_elem[k-1];
                            n_prio[k] = r_prio[k-1];
                        end
                    end
                end
            end else begin
                n_count = r_count - CW'(1);
                // advance every cell one place toward the front
                for (int k = 0; k < CAP - 1; k++) begin
                    n_elem[k] = r_elem[k+1];
                    n_prio[k] = r_prio[k+1];
                end
            end
        end
    end

    always_comb begin
        n_out.item_count = n_count;
        n_out.is_empty   = (n_count == '0);
        n_out.is_full    = (n_count == CW'(CAP));
        n_out.error      = fault;
        if (n_count == '0) begin
            n_out.front_elem     = '0;
            n_out.front_priority = '0;
        end else begin
            n_out.front_elem     = n_elem[0];
            n_out.front_priority = n_prio[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_word;
        end
        if (i_cmd.exec) begin
            for (int k = 0; k < CAP; k++) begin
                r_elem[k] <= n_elem[k];
                r_prio[k] <= n_prio[k];
            end
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// Top level of the sorted min-priority queue: controller plus cell datapath.
// o_valid and the result word are registered at the end of the execute state and are taken at the next edge.
// A new word is not accepted while the single execute step of the cell row is in progress.
// busy is high during the execute cycle; the result is never stalled by the receiver.
// Reset (synchronous, active low) empties the queue and clears control state.
`timescale 1ns / 1ps

module sorted_priority_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::t_in_word  i_word,
    output logic               o_valid,
    output spq_pkg::t_out_word o_word
);

    spq_pkg::t_dp_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    spq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_word  (i_word),
        .o_word  (o_word)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the sorted min-priority queue.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        t_in_word  word;
        bit        pinned;
        t_out_word want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_word;
    logic      o_valid;
    t_out_word o_word;

    // expectation typed into the directed table, travels with the word
    logic      pin_on;
    t_out_word pin_word;

    logic [ELEM_WIDTH-1:0] queue_elem [CAPACITY];
    logic [PRIO_WIDTH-1:0] queue_prio [CAPACITY];
    int                    queue_count;

    t_out_word expected_fronts [$];
    int        mismatch_count;
    int        cycle_count;

    sorted_priority_queue_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    always #5 i_clk = ~i_clk;

    // Apply one operation to the local queue and return the front it leaves.
    function automatic t_out_word apply_queue_op(input t_in_word w);
        t_out_word res;
        int        pos;
        bit        refused;
        refused = 1'b0;
        if (w.mode == MODE_ENQ) begin
            if (queue_count >= CAPACITY) begin
                refused = 1'b1;
            end else begin
                pos = 0;
                // equal priority goes behind, so ties leave in arrival order
                while (pos < queue_count && queue_prio[pos] <= w.priority_req) pos++;
                for (int k = queue_count; k > pos; k--) begin
                    queue_elem[k] = queue_elem[k-1];
                    queue_prio[k] = queue_prio[k-1];
                end
                queue_elem[pos] = w.elem;
                queue_prio[pos] = w.priority_req;
                queue_count++;
            end
        end else begin
            if (queue_count == 0) begin
                refused = 1'b1;
            end else begin
                for (int k = 0; k + 1 < queue_count; k++) begin
                    queue_elem[k] = queue_elem[k+1];
                    queue_prio[k] = queue_prio[k+1];
                end
                queue_count--;
            end
        end
        res.front_elem     = (queue_count > 0) ? queue_elem[0] : '0;
        res.front_priority = (queue_count > 0) ? queue_prio[0] : '0;
        res.item_count     = COUNT_W'(queue_count);
        res.is_empty       = (queue_count == 0);
        res.is_full        = (queue_count >= CAPACITY);
        res.error          = refused;
        return res;
    endfunction

    function automatic t_stim_row enq_row(input logic [ELEM_WIDTH-1:0] e,
                                          input logic [PRIO_WIDTH-1:0] p);
        t_stim_row r;
        r.word   = '{mode: MODE_ENQ, elem: e, priority_req: p};
        r.pinned = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_stim_row pinned_row(input logic m,
                                             input logic [ELEM_WIDTH-1:0] e,
                                             input logic [PRIO_WIDTH-1:0] p,
                                             input logic [ELEM_WIDTH-1:0] fe,
                                             input logic [PRIO_WIDTH-1:0] fp,
                                             input int cnt,
                                             input logic emp,
                                             input logic ful,
                                             input logic err);
        t_stim_row r;
        r.word   = '{mode: m, elem: e, priority_req: p};
        r.pinned = 1'b1;
        r.want   = '{front_elem: fe, front_priority: fp, item_count: COUNT_W'(cnt),
                     is_empty: emp, is_full: ful, error: err};
        return r;
    endfunction

    function automatic t_in_word random_word(input int enq_pct);
        t_in_word w;
        int       r;
        w.mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        r = $urandom_range(0, 9);
        w.elem = (r == 0) ? '0 : (r == 1) ? '1 : ELEM_WIDTH'($urandom);
        r = $urandom_range(0, 9);
        // mostly a narrow range so ties are common
        if (r < 5)       w.priority_req = PRIO_WIDTH'($urandom_range(0, 7));
        else if (r < 8)  w.priority_req = PRIO_WIDTH'($urandom);
        else if (r == 8) w.priority_req = '0;
        else             w.priority_req = '1;
        return w;
    endfunction

    function automatic int pick_gap(input bit idle_on);
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Hold the word on the port until the block takes it.
    task automatic issue(input t_in_word w, input bit pin, input t_out_word pw);
        start    <= 1'b1;
        i_word   <= w;
        pin_on   <= pin;
        pin_word <= pw;
        do @(posedge i_clk); while (!(start && !busy));
    endtask

    task automatic rest(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word pred;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_fronts.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = expected_fronts.pop_front();
                    cmp_field("front_elem", 32'(want.front_elem),
                              32'(o_word.front_elem));
                    cmp_field("front_priority", 32'(want.front_priority),
                              32'(o_word.front_priority));
                    cmp_field("item_count", 32'(want.item_count),
                              32'(o_word.item_count));
                    cmp_field("is_empty", 32'(want.is_empty), 32'(o_word.is_empty));
                    cmp_field("is_full", 32'(want.is_full), 32'(o_word.is_full));
                    cmp_field("error", 32'(want.error), 32'(o_word.error));
                end
            end
            if (start && !busy) begin
                pred = apply_queue_op(i_word);
                expected_fronts.push_back(pin_on ? pin_word : pred);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_stim_row dir_rows [$];
        int        sent;
        int        phase_len;
        int        enq_pct;
        int        gap;
        bit        idle_on;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_word         = '0;
        pin_on         = 1'b0;
        pin_word       = '0;
        queue_count    = 0;
        mismatch_count = 0;
        cycle_count    = 0;

        // dequeue on empty, extremes, ties at both ends
        dir_rows.push_back(pinned_row(MODE_DEQ, 32'h0, 16'h0,
                                      32'h0, 16'h0, 0, 1'b1, 1'b0, 1'b1));
        dir_rows.push_back(pinned_row(MODE_ENQ, 32'hFFFF_FFFF, 16'hFFFF,
                                      32'hFFFF_FFFF, 16'hFFFF, 1, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(pinned_row(MODE_ENQ, 32'h0, 16'h0,
                                      32'h0, 16'h0, 2, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(enq_row(32'h0000_0001, 16'hFFFF));
        dir_rows.push_back(pinned_row(MODE_ENQ, 32'h1234_5678, 16'h0,
                                      32'h0, 16'h0, 4, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(pinned_row(MODE_DEQ, 32'hFFFF_FFFF, 16'hFFFF,
                                      32'h1234_5678, 16'h0, 3, 1'b0, 1'b0, 1'b0));
        // fill up, front stays put
        dir_rows.push_back(enq_row(32'h5555_5555, 16'h8000));
        dir_rows.push_back(enq_row(32'hAAAA_AAAA, 16'h0001));
        dir_rows.push_back(enq_row(32'hA5A5_A5A5, 16'h0001));
        dir_rows.push_back(enq_row(32'h5A5A_5A5A, 16'h7FFF));
        dir_rows.push_back(enq_row(32'h0F0F_0F0F, 16'hFFFE));
        dir_rows.push_back(enq_row(32'hF0F0_F0F0, 16'h0002));
        dir_rows.push_back(enq_row(32'h8000_0000, 16'h0001));
        dir_rows.push_back(enq_row(32'h7FFF_FFFF, 16'h8000));
        dir_rows.push_back(enq_row(32'hDEAD_BEEF, 16'h0003));
        dir_rows.push_back(enq_row(32'h0000_0002, 16'hFFFF));
        dir_rows.push_back(enq_row(32'hCAFE_0001, 16'h5555));
        dir_rows.push_back(enq_row(32'h0BAD_F00D, 16'hAAAA));
        dir_rows.push_back(enq_row(32'h1357_9BDF, 16'h0002));
        dir_rows.push_back(pinned_row(MODE_ENQ, 32'h2468_ACE0, 16'h0000,
                                      32'h1234_5678, 16'h0, 16, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(pinned_row(MODE_DEQ, 32'h0, 16'h0,
                                      32'hAAAA_AAAA, 16'h0001, 15, 1'b0, 1'b0, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            issue(dir_rows[n].word, dir_rows[n].pinned, dir_rows[n].want);
            gap = pick_gap(n >= 10);
            if (gap > 0) rest(gap);
        end

        // phases lean toward filling, draining or a mix
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            phase_len = $urandom_range(10, 40);
            idle_on   = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
                issue(random_word(enq_pct), 1'b0, '0);
                sent++;
                gap = pick_gap(idle_on);
                if (gap > 0) rest(gap);
            end
        end
        start <= 1'b0;

        while (expected_fronts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
